// ----- src/afe_pkg.sv -----
// ----------------------------------------------------------------------------
// afe_pkg
// Shared types, constants and register codes of the auto-exposure unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package afe_pkg;

  // Default sizes
  localparam int NUM_CAMERAS_DEF = 4;
  localparam int NUM_BINS_DEF    = 64;

  // Field widths
  localparam int CAM_W   = 2;
  localparam int BIN_W   = 6;
  localparam int CNT_W   = 24;
  localparam int EXP_W   = 16;
  localparam int MEAN_W  = 22;
  localparam int WSUM_W  = 40;
  localparam int PTOT_W  = 32;
  localparam int FCNT_W  = 3;
  localparam int GAIN_W  = 32;
  localparam int DEC_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 22;

  // Fixed-point limits
  localparam logic [MEAN_W-1:0] MEAN_MAX      = 22'h3FFFFF;
  localparam logic [MEAN_W-1:0] MIN_MEAN_DIFF = 22'd655;
  localparam logic [30:0]       GAIN_MAX      = 31'h7FFFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_ONE      = 32'd65536;

  // Divider length: dividend is the weighted sum shifted up by 16
  localparam int DIV_STEPS = WSUM_W + 16;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAXEXP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCUM  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP  = 3'd6;

  // Register reset values
  localparam logic [MEAN_W-1:0] TARGET_RST = 22'd1589575;
  localparam logic [MEAN_W-1:0] BAND_RST   = 22'd227082;
  localparam logic [DEC_W-1:0]  DECAY_RST  = 17'd26214;
  localparam logic [EXP_W-1:0]  MAXEXP_RST = 16'd20480;
  localparam logic [FCNT_W-1:0] SKIP_RST   = 3'd1;
  localparam logic [FCNT_W-1:0] ACCUM_RST  = 3'd3;

  typedef struct packed {
    logic [MEAN_W-1:0] target_mean;
    logic [MEAN_W-1:0] band_half_width;
    logic [DEC_W-1:0]  decay_gain;
    logic [EXP_W-1:0]  exp_ceiling;
    logic [FCNT_W-1:0] skip_frames;
    logic [FCNT_W-1:0] accumulate_frames;
    logic              group_mode;
  } cfg_t;

  // One finished frame handed from front to back
  typedef struct packed {
    logic [CAM_W-1:0]  cam;
    logic [WSUM_W-1:0] wsum;
    logic [PTOT_W-1:0] ptot;
    logic [EXP_W-1:0]  cur;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// ----- src/afe_front.sv -----
// ----------------------------------------------------------------------------
// afe_front
// Accepts histogram bins, accumulates per camera and queues finished frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_front #(
  parameter int NUM_CAMERAS = afe_pkg::NUM_CAMERAS_DEF,
  parameter int NUM_BINS    = afe_pkg::NUM_BINS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [afe_pkg::CAM_W-1:0] cam,
  input  wire logic [afe_pkg::BIN_W-1:0] bin,
  input  wire logic [afe_pkg::CNT_W-1:0] cnt,
  input  wire logic [afe_pkg::EXP_W-1:0] cur,
  input  wire afe_pkg::cfg_t            cfg,
  input  wire afe_pkg::q_stat_t         q_stat,
  output logic                          q_push,
  output afe_pkg::job_t                 q_job
);

  localparam int CIW = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;

  logic [afe_pkg::WSUM_W-1:0] wsum_r [NUM_CAMERAS];
  logic [afe_pkg::PTOT_W-1:0] ptot_r [NUM_CAMERAS];
  logic [afe_pkg::FCNT_W-1:0] fcnt_r [NUM_CAMERAS];

  logic [CIW-1:0]             idx;
  logic                       take, last, counted, eval;
  logic [29:0]                bc;
  logic [afe_pkg::WSUM_W:0]   wsum_add;
  logic [afe_pkg::PTOT_W:0]   ptot_add;
  logic [afe_pkg::WSUM_W-1:0] wsum_nxt;
  logic [afe_pkg::PTOT_W-1:0] ptot_nxt;
  logic [afe_pkg::FCNT_W:0]   n;

  assign in_ready = !q_stat.full;
  assign idx      = CIW'(cam);

  // Drop bins of unregulated or out-of-range cameras and bins
  assign take = in_valid && in_ready && !(cfg.group_mode && (cam != '0)) &&
                (32'(cam) < NUM_CAMERAS) && (32'(bin) < NUM_BINS);
  assign last = (32'(bin) == NUM_BINS - 1);

  // Accumulate with saturation once the skip window has passed
  assign counted  = (fcnt_r[idx] >= cfg.skip_frames);
  assign bc       = 30'(bin) * 30'(cnt);
  assign wsum_add = {1'b0, wsum_r[idx]} + 41'(bc);
  assign ptot_add = {1'b0, ptot_r[idx]} + 33'(cnt);
  assign wsum_nxt = !counted ? wsum_r[idx] :
                    (wsum_add[afe_pkg::WSUM_W] ? '1 : wsum_add[afe_pkg::WSUM_W-1:0]);
  assign ptot_nxt = !counted ? ptot_r[idx] :
                    (ptot_add[afe_pkg::PTOT_W] ? '1 : ptot_add[afe_pkg::PTOT_W-1:0]);

  // Frame end decision
  assign n    = {1'b0, fcnt_r[idx]} + 4'd1;
  assign eval = last && (n > {1'b0, cfg.skip_frames}) && (n > {1'b0, cfg.accumulate_frames});

  assign q_push     = take && eval;
  assign q_job.cam  = cam;
  assign q_job.wsum = wsum_nxt;
  assign q_job.ptot = ptot_nxt;
  assign q_job.cur  = cur;

  // Update per-camera accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CAMERAS; c++) begin
        wsum_r[c] <= '0;
        ptot_r[c] <= '0;
        fcnt_r[c] <= '0;
      end
    end else if (take) begin
      if (eval) begin
        wsum_r[idx] <= '0;
        ptot_r[idx] <= '0;
        fcnt_r[idx] <= '0;
      end else begin
        wsum_r[idx] <= wsum_nxt;
        ptot_r[idx] <= ptot_nxt;
        if (last) begin
          fcnt_r[idx] <= n[afe_pkg::FCNT_W-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/afe_queue.sv -----
// ----------------------------------------------------------------------------
// afe_queue
// Two-entry queue of finished frames between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire afe_pkg::job_t wr_job,
  input  wire logic          pop,
  output afe_pkg::job_t      rd_job,
  output afe_pkg::q_stat_t   stat
);

  afe_pkg::job_t ent_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign rd_job     = ent_r[rp_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wr_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- src/afe_back.sv -----
// ----------------------------------------------------------------------------
// afe_back
// Evaluates one frame: mean by division, secant gain, new exposure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_back #(
  parameter int NUM_CAMERAS = afe_pkg::NUM_CAMERAS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire afe_pkg::cfg_t              cfg,
  input  wire afe_pkg::q_stat_t           q_stat,
  input  wire afe_pkg::job_t              q_job,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [afe_pkg::CAM_W-1:0]       out_camera,
  output logic [afe_pkg::EXP_W-1:0]       out_exposure,
  output logic                            apply_to_all,
  output logic [afe_pkg::MEAN_W-1:0]      measured_mean
);

  localparam int CIW = (NUM_CAMERAS > 1) ? $clog2(NUM_CAMERAS) : 1;
  localparam int DW  = afe_pkg::DIV_STEPS;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_EVAL = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_KLO  = 9'b000010000,
    S_KHI  = 9'b000100000,
    S_KSUM = 9'b001000000,
    S_DLT  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Per-camera regulator history
  logic [afe_pkg::MEAN_W-1:0] pm_r [NUM_CAMERAS];
  logic                       pv_r [NUM_CAMERAS];
  logic [afe_pkg::GAIN_W-1:0] pg_r [NUM_CAMERAS];

  afe_pkg::job_t               job_r;
  logic [CIW-1:0]              idx;
  logic [DW-1:0]               dvd_r;
  logic [31:0]                 rem_r, dvs_r;
  logic [afe_pkg::DCNT_W-1:0]  dcnt_r;
  logic                        phase_r;
  logic [afe_pkg::MEAN_W-1:0]  mean_r, xmag_r, denmag_r;
  logic                        xneg_r, kneg_r;
  logic [30:0]                 kmag_r;
  logic [40:0]                 pl_r;
  logic [39:0]                 ph_r;
  logic [52:0]                 dp_r;
  logic                        ov_r;
  logic [afe_pkg::CAM_W-1:0]   ocam_r;
  logic [afe_pkg::EXP_W-1:0]   oexp_r;
  logic                        oall_r;
  logic [afe_pkg::MEAN_W-1:0]  omean_r;

  // Divider step
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  // Evaluation terms
  logic signed [23:0] tgt, m, pm, x, pmx, den, lo, hi;
  logic               outside, sgn_eq, secant;
  logic [23:0]        xabs, dabs;
  logic [afe_pkg::GAIN_W-1:0] g, gmag;
  logic [53:0]        gx;
  logic [63:0]        ktot;
  logic [47:0]        ksh;
  logic [30:0]        delta;
  logic [31:0]        c32, d32, sum32, dif32;
  logic [afe_pkg::EXP_W-1:0] res;
  logic               out_free;

  assign idx      = CIW'(job_r.cam);
  assign out_free = !ov_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;

  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = !rem_sub[32];

  // Band test and secant conditions
  assign tgt     = signed'({2'b00, cfg.target_mean});
  assign m       = signed'({2'b00, mean_r});
  assign pm      = signed'({2'b00, pm_r[idx]});
  assign lo      = tgt - signed'({2'b00, cfg.band_half_width});
  assign hi      = tgt + signed'({2'b00, cfg.band_half_width});
  assign outside = (m < lo) || (m > hi);
  assign x       = tgt - m;
  assign pmx     = tgt - pm;
  assign den     = pm - m;
  assign xabs    = x[23] ? 24'(-x) : 24'(x);
  assign dabs    = den[23] ? 24'(-den) : 24'(den);
  assign sgn_eq  = (x[23] == pmx[23]) && ((x == 24'sd0) == (pmx == 24'sd0));
  assign secant  = outside && pv_r[idx] && sgn_eq &&
                   (dabs[afe_pkg::MEAN_W-1:0] > afe_pkg::MIN_MEAN_DIFF);

  assign g    = pg_r[idx];
  assign gmag = g[31] ? (32'd0 - g) : g;
  assign gx   = gmag * xmag_r;

  // Gain scale and saturation
  assign ktot = {ph_r, 24'd0} + {23'd0, pl_r};
  assign ksh  = ktot[63:16];

  // New exposure
  assign delta = dp_r[52:22];
  assign c32   = {16'd0, job_r.cur};
  assign d32   = {1'b0, delta};
  assign sum32 = c32 + d32;
  assign dif32 = c32 - d32;
  always_comb begin
    if (xneg_r) begin
      if (d32 > c32) begin
        res = job_r.cur >> 1;
      end else if (dif32 > {16'd0, cfg.exp_ceiling}) begin
        res = cfg.exp_ceiling;
      end else begin
        res = dif32[15:0];
      end
    end else if (sum32 > {16'd0, cfg.exp_ceiling}) begin
      res = cfg.exp_ceiling;
    end else begin
      res = sum32[15:0];
    end
  end

  // Sequence
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_stat.empty) state_nxt = (q_job.ptot == '0) ? S_EVAL : S_DIV;
      S_DIV:  if (32'(dcnt_r) == DW - 1) state_nxt = phase_r ? S_KLO : S_EVAL;
      S_EVAL: state_nxt = secant ? S_MUL : S_DLT;
      S_MUL:  state_nxt = S_DIV;
      S_KLO:  state_nxt = ((cfg.decay_gain == '0) || (|dvd_r[DW-1:47])) ? S_DLT : S_KHI;
      S_KHI:  state_nxt = S_KSUM;
      S_KSUM: state_nxt = S_DLT;
      S_DLT:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r   <= q_job;
        dvd_r   <= {q_job.wsum, 16'd0};
        rem_r   <= '0;
        dvs_r   <= q_job.ptot;
        dcnt_r  <= '0;
        phase_r <= 1'b0;
        mean_r  <= '0;
      end
      S_DIV: begin
        rem_r  <= ge ? rem_sub[31:0] : rem_sh[31:0];
        dvd_r  <= {dvd_r[DW-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
        if (!phase_r && (32'(dcnt_r) == DW - 1)) begin
          mean_r <= (|dvd_r[DW-2:21]) ? afe_pkg::MEAN_MAX :
                    {dvd_r[20:0], ge};
        end
      end
      S_EVAL: begin
        xmag_r   <= outside ? xabs[afe_pkg::MEAN_W-1:0] : '0;
        xneg_r   <= outside && x[23];
        denmag_r <= dabs[afe_pkg::MEAN_W-1:0];
        // Gain stays positive unless the secant step is taken
        kneg_r   <= secant && (g[31] ^ x[23] ^ den[23]);
        kmag_r   <= 31'(cfg.decay_gain);
      end
      S_MUL: begin
        dvd_r   <= DW'(gx);
        rem_r   <= '0;
        dvs_r   <= 32'(denmag_r);
        dcnt_r  <= '0;
        phase_r <= 1'b1;
      end
      S_KLO: begin
        if (cfg.decay_gain == '0) begin
          kmag_r <= '0;
        end else if (|dvd_r[DW-1:47]) begin
          kmag_r <= afe_pkg::GAIN_MAX;
        end
        pl_r <= dvd_r[23:0] * cfg.decay_gain;
      end
      S_KHI: begin
        ph_r <= dvd_r[46:24] * cfg.decay_gain;
      end
      S_KSUM: begin
        kmag_r <= (|ksh[47:31]) ? afe_pkg::GAIN_MAX : ksh[30:0];
      end
      S_DLT: begin
        dp_r <= xmag_r * kmag_r;
      end
      default: begin
      end
    endcase
  end

  // Regulator history per camera
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CAMERAS; c++) begin
        pm_r[c] <= '0;
        pv_r[c] <= 1'b0;
        pg_r[c] <= afe_pkg::GAIN_ONE;
      end
    end else if ((state_r == S_FIN) && out_free) begin
      pm_r[idx] <= mean_r;
      pv_r[idx] <= 1'b1;
      pg_r[idx] <= kneg_r ? (32'd0 - {1'b0, kmag_r}) : {1'b0, kmag_r};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if ((state_r == S_FIN) && out_free) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && out_free) begin
      ocam_r  <= job_r.cam;
      oexp_r  <= res;
      oall_r  <= cfg.group_mode;
      omean_r <= mean_r;
    end
  end

  assign out_valid     = ov_r;
  assign out_camera    = ocam_r;
  assign out_exposure  = oexp_r;
  assign apply_to_all  = oall_r;
  assign measured_mean = omean_r;

endmodule

`default_nettype wire

// ----- src/histogram_auto_exposure_unit.sv -----
// ----------------------------------------------------------------------------
// histogram_auto_exposure_unit
// Per-camera histogram-mean auto-exposure regulator with secant gain.
// ----------------------------------------------------------------------------
// Bins are taken one per clock while the two-entry frame queue has room.
// A frame that is evaluated costs the back part a 56-step shift-subtract
// division for the mean, plus a second pass of the same divider and two
// partial products when the secant gain is taken. The single shared divider
// sets the evaluation rate; bins of the next frame keep flowing in while it
// runs, as long as the queue has room. Results wait in an output register.
`timescale 1ns / 1ps
`default_nettype none

module histogram_auto_exposure_unit #(
  parameter int NUM_CAMERAS = afe_pkg::NUM_CAMERAS_DEF,
  parameter int NUM_BINS    = afe_pkg::NUM_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // bin_index[5:0], bin_count[29:6], current_exposure[45:30]
  input  wire logic [1:0]  in_tuser,   // camera_index[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // exposure[15:0], measured_mean[37:16]
  output logic [2:0]       out_tuser,  // out_camera[1:0], apply_to_all[2]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [21:0] cfg_data
);

  afe_pkg::cfg_t    cfg_r;
  afe_pkg::q_stat_t q_stat;
  afe_pkg::job_t    push_job, pop_job;
  logic             q_push, q_pop;
  logic [afe_pkg::EXP_W-1:0]  upd_exposure;
  logic [afe_pkg::MEAN_W-1:0] measured_mean;
  logic [afe_pkg::CAM_W-1:0]  out_camera;
  logic                       apply_to_all;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_mean       <= afe_pkg::TARGET_RST;
      cfg_r.band_half_width   <= afe_pkg::BAND_RST;
      cfg_r.decay_gain        <= afe_pkg::DECAY_RST;
      cfg_r.exp_ceiling       <= afe_pkg::MAXEXP_RST;
      cfg_r.skip_frames       <= afe_pkg::SKIP_RST;
      cfg_r.accumulate_frames <= afe_pkg::ACCUM_RST;
      cfg_r.group_mode        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        afe_pkg::CFG_TARGET: cfg_r.target_mean       <= cfg_data;
        afe_pkg::CFG_BAND:   cfg_r.band_half_width   <= cfg_data;
        afe_pkg::CFG_DECAY:  cfg_r.decay_gain        <= cfg_data[16:0];
        afe_pkg::CFG_MAXEXP: cfg_r.exp_ceiling       <= cfg_data[15:0];
        afe_pkg::CFG_SKIP:   cfg_r.skip_frames       <= cfg_data[2:0];
        afe_pkg::CFG_ACCUM:  cfg_r.accumulate_frames <= cfg_data[2:0];
        afe_pkg::CFG_GROUP:  cfg_r.group_mode        <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  afe_front #(.NUM_CAMERAS(NUM_CAMERAS), .NUM_BINS(NUM_BINS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cam      (in_tuser),
    .bin      (in_tdata[5:0]),
    .cnt      (in_tdata[29:6]),
    .cur      (in_tdata[45:30]),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  afe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (push_job),
    .pop    (q_pop),
    .rd_job (pop_job),
    .stat   (q_stat)
  );

  afe_back #(.NUM_CAMERAS(NUM_CAMERAS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_job         (pop_job),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_camera    (out_camera),
    .out_exposure  (upd_exposure),
    .apply_to_all  (apply_to_all),
    .measured_mean (measured_mean)
  );

  assign out_tdata = {2'b00, measured_mean, upd_exposure};
  assign out_tuser = {apply_to_all, out_camera};

endmodule

`default_nettype wire

// ----- src/afe_checker.sv -----
// ----------------------------------------------------------------------------
// afe_checker
// Port-level checks of the auto-exposure unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module afe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic        cfg_ready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Keep the padding bits of a result beat at zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:38] == 2'b00))
    else $error("result padding bits not zero");

  // Configuration is always taken
  a_cfg_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("configuration port stalled");

endmodule

bind histogram_auto_exposure_unit afe_checker u_afe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);

`default_nettype wire

// ----- bench/histogram_auto_exposure_unit_tb.sv -----
// ----------------------------------------------------------------------------
// histogram_auto_exposure_unit_tb
// Self-checking bench for the per-camera histogram auto-exposure regulator.
// ----------------------------------------------------------------------------
// Drives histogram bin beats with random idling and back-pressure, keeps a
// cycle-free model of every camera's accumulators and secant gain, and checks
// each exposure update beat field by field against the oldest prediction.
// Runs through default, extreme and random register settings.
`timescale 1ns / 1ps
`default_nettype none

module histogram_auto_exposure_unit_tb;

  localparam int  NCAM       = 4;
  localparam int  LAST_BIN   = 63;
  localparam int  DRAIN_CYC  = 300;
  localparam int  CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [afe_pkg::CAM_W-1:0]  cam;
    logic [afe_pkg::EXP_W-1:0]  exposure;
    logic                       all;
    logic [afe_pkg::MEAN_W-1:0] mean;
  } update_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // bin_index[5:0], bin_count[29:6], current_exposure[45:30]
  logic [1:0]  in_tuser = '0;   // camera_index[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // exposure[15:0], measured_mean[37:16]
  logic [2:0]  out_tuser;       // out_camera[1:0], apply_to_all[2]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  histogram_auto_exposure_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model copy of the registers
  longint unsigned m_target, m_band, m_decay, m_maxexp, m_skip, m_accum, m_group;
  // Model copy of the per-camera state
  longint unsigned m_wsum [NCAM];
  longint unsigned m_ptot [NCAM];
  longint unsigned m_fcnt [NCAM];
  longint unsigned m_pmean [NCAM];
  bit              m_pvalid [NCAM];
  logic [31:0]     m_pgain [NCAM];

  update_t pending_updates [$];
  int      errors = 0;
  int      updates_seen = 0;
  int      bins_sent = 0;
  int      cycles = 0;
  int      hold_left = 0;
  bit      no_idle = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Cycle count and run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at %0t after %0d cycles", $time, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Count down a receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // Receiver readiness
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= 26);
    end
  end

  // Compare each accepted update beat with the oldest prediction
  always @(posedge clk) begin
    update_t want;
    if (rst_n && out_tvalid && out_tready) begin
      updates_seen <= updates_seen + 1;
      if (pending_updates.size() == 0) begin
        $display("%0t: update expected none actual cam=%0d exp=%0d", $time, out_tuser[1:0],
                 out_tdata[15:0]);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (out_tuser[1:0] !== want.cam) begin
          $display("%0t: camera expected %0d actual %0d", $time, want.cam, out_tuser[1:0]);
          errors++;
        end
        if (out_tdata[15:0] !== want.exposure) begin
          $display("%0t: exposure expected %0d actual %0d", $time, want.exposure,
                   out_tdata[15:0]);
          errors++;
        end
        if (out_tuser[2] !== want.all) begin
          $display("%0t: apply_to_all expected %0d actual %0d", $time, want.all, out_tuser[2]);
          errors++;
        end
        if (out_tdata[37:16] !== want.mean) begin
          $display("%0t: mean expected %0d actual %0d", $time, want.mean, out_tdata[37:16]);
          errors++;
        end
      end
    end
  end

  function automatic int sign_of(input longint v);
    return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
  endfunction

  function automatic longint unsigned abs_of(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Advance one camera's exposure regulator by one bin beat
  function automatic void regulate_bin(input logic [1:0] cam, input logic [5:0] bin,
                                       input logic [23:0] cnt, input logic [15:0] cur);
    longint unsigned w, p, n, mean, kmag, gmag, q, res;
    longint tgt, m, x, pm, den, delta, nexp;
    int ksign, gsign;
    update_t upd;
    if (m_group != 0 && cam != 0) return;
    if (m_fcnt[cam] >= m_skip) begin
      w = m_wsum[cam] + longint'(bin) * longint'(cnt);
      p = m_ptot[cam] + longint'(cnt);
      m_wsum[cam] = (w > 64'hFF_FFFF_FFFF) ? 64'hFF_FFFF_FFFF : w;
      m_ptot[cam] = (p > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : p;
    end
    if (bin != LAST_BIN) return;
    n = m_fcnt[cam] + 1;
    if (!(n > m_skip && n > m_accum)) begin
      m_fcnt[cam] = n & 7;
      return;
    end
    mean = 0;
    if (m_ptot[cam] != 0) begin
      mean = (m_wsum[cam] << 16) / m_ptot[cam];
      if (mean > afe_pkg::MEAN_MAX) mean = afe_pkg::MEAN_MAX;
    end
    tgt = longint'(m_target);
    m = longint'(mean);
    x = tgt - m;
    kmag = m_decay;
    ksign = 1;
    if (m < tgt - longint'(m_band) || m > tgt + longint'(m_band)) begin
      if (m_pvalid[cam]) begin
        pm = longint'(m_pmean[cam]);
        den = pm - m;
        if (sign_of(x) == sign_of(tgt - pm) && abs_of(den) > afe_pkg::MIN_MEAN_DIFF) begin
          gsign = m_pgain[cam][31] ? -1 : 1;
          gmag = m_pgain[cam][31] ? longint'(32'(-m_pgain[cam])) : longint'(m_pgain[cam]);
          q = (gmag * abs_of(x)) / abs_of(den);
          q = (q * m_decay) >> 16;
          kmag = (q > afe_pkg::GAIN_MAX) ? afe_pkg::GAIN_MAX : q;
          ksign = gsign * sign_of(x) * sign_of(den);
        end
      end
    end else begin
      x = 0;
    end
    delta = longint'((abs_of(x) * kmag) >> 22);
    if (x < 0) delta = -delta;
    nexp = longint'(cur) + delta;
    if (nexp < 0) res = cur >> 1;
    else if (nexp > longint'(m_maxexp)) res = m_maxexp;
    else res = nexp;
    upd.cam = cam;
    upd.exposure = res[15:0];
    upd.all = m_group[0];
    upd.mean = mean[21:0];
    pending_updates.insert(pending_updates.size(), upd);
    m_wsum[cam] = 0;
    m_ptot[cam] = 0;
    m_fcnt[cam] = 0;
    m_pmean[cam] = mean;
    m_pvalid[cam] = 1'b1;
    m_pgain[cam] = (ksign < 0) ? 32'(-kmag[31:0]) : kmag[31:0];
  endfunction

  // Offer one bin beat, wait for acceptance, then maybe idle
  task automatic send_bin(input logic [1:0] cam, input logic [5:0] bin,
                          input logic [23:0] cnt, input logic [15:0] cur);
    int gap;
    in_tdata <= {2'b00, cur, cnt, bin};
    in_tuser <= cam;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    regulate_bin(cam, bin, cnt, cur);
    bins_sent++;
    if (!no_idle && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
    cfg_index <= idx;
    cfg_data <= val[21:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      afe_pkg::CFG_TARGET: m_target = val & 22'h3FFFFF;
      afe_pkg::CFG_BAND:   m_band = val & 22'h3FFFFF;
      afe_pkg::CFG_DECAY:  m_decay = val & 17'h1FFFF;
      afe_pkg::CFG_MAXEXP: m_maxexp = val & 16'hFFFF;
      afe_pkg::CFG_SKIP:   m_skip = val & 3'h7;
      afe_pkg::CFG_ACCUM:  m_accum = val & 3'h7;
      afe_pkg::CFG_GROUP:  m_group = val & 1'b1;
      default: ;
    endcase
  endtask

  // Hold until every predicted update has come, then let the back stage settle
  task automatic drain();
    stop_sending();
    wait (pending_updates.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_all(input longint unsigned tg, bd, dc, mx, sk, ac, gp);
    write_reg(afe_pkg::CFG_TARGET, tg);
    write_reg(afe_pkg::CFG_BAND, bd);
    write_reg(afe_pkg::CFG_DECAY, dc);
    write_reg(afe_pkg::CFG_MAXEXP, mx);
    write_reg(afe_pkg::CFG_SKIP, sk);
    write_reg(afe_pkg::CFG_ACCUM, ac);
    write_reg(afe_pkg::CFG_GROUP, gp);
  endtask

  function automatic logic [23:0] pick_count();
    case ($urandom_range(5))
      0: return 24'hFFFFFF;
      1: return 24'd0;
      2: return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_exposure();
    case ($urandom_range(7))
      0: return 16'hFFFF;
      1: return 16'd0;
      default: return 16'($urandom);
    endcase
  endfunction

  // Short frame: a few random bins then the closing bin
  task automatic send_frame(input logic [1:0] cam, input int nbins);
    repeat (nbins) send_bin(cam, 6'($urandom_range(0, LAST_BIN - 1)), pick_count(), 16'($urandom));
    send_bin(cam, 6'(LAST_BIN), pick_count(), pick_exposure());
  endtask

  task automatic test_default_regs();
    for (int f = 0; f < 12; f++) send_frame(2'(f % NCAM), $urandom_range(0, 3));
    drain();
  endtask

  // Field extremes with tight frames on cameras 0, 1 and 3
  task automatic test_extremes();
    set_all(0, 0, 65536, 65535, 0, 1, 0);
    send_bin(2'd3, 6'd0, 24'hFFFFFF, 16'hFFFF);
    send_bin(2'd3, 6'(LAST_BIN), 24'hFFFFFF, 16'hFFFF);
    send_bin(2'd3, 6'd0, 24'd1, 16'd0);
    send_bin(2'd3, 6'(LAST_BIN), 24'd0, 16'd0);
    send_bin(2'd0, 6'd62, 24'hFFFFFF, 16'd0);
    send_bin(2'd0, 6'(LAST_BIN), 24'd5, 16'hFFFF);
    send_bin(2'd0, 6'd1, 24'd7, 16'd1);
    send_bin(2'd0, 6'(LAST_BIN), 24'd0, 16'h8000);
    drain();
    set_all(4194303, 4194303, 0, 1, 7, 7, 0);
    for (int f = 0; f < 8; f++) send_frame(2'd1, 1);
    drain();
  endtask

  task automatic test_zero_pixels();
    set_all(1589575, 1000, 65536, 40000, 0, 1, 0);
    for (int f = 0; f < 4; f++) begin
      send_bin(2'd2, 6'd10, 24'd0, 16'd0);
      send_bin(2'd2, 6'(LAST_BIN), 24'd0, 16'd30000);
    end
    drain();
  endtask

  // Other cameras' bins are ignored while grouped
  task automatic test_group_mode();
    write_reg(afe_pkg::CFG_GROUP, 1);
    for (int f = 0; f < 10; f++) send_frame(2'($urandom_range(0, 3)), 2);
    drain();
    write_reg(afe_pkg::CFG_GROUP, 0);
  endtask

  // Full-height frames until the pixel-total accumulator saturates
  task automatic test_saturation();
    set_all(100000, 10, 65536, 65535, 0, 7, 0);
    for (int f = 0; f < 8; f++)
      for (int b = 0; b <= LAST_BIN; b++)
        send_bin(2'd1, 6'(b), 24'hFFFFFF, 16'd12345);
    drain();
  endtask

  task automatic test_accum_below_skip();
    set_all(2000000, 50000, 40000, 30000, 3, 1, 0);
    for (int f = 0; f < 12; f++) send_frame(2'd2, 1);
    drain();
  endtask

  // Stall the receiver long enough that the input backs up
  task automatic test_backpressure();
    set_all(1589575, 200000, 26214, 20480, 0, 1, 0);
    hold_left = 600;
    for (int f = 0; f < 20; f++) send_frame(2'(f % NCAM), 0);
    drain();
    for (int f = 0; f < 6; f++) send_frame(2'(f % NCAM), 2);
    drain();
  endtask

  // Random settings with mostly well-formed short frames and some stray bins
  task automatic test_random();
    int start_bins, start_updates;
    for (int ph = 0; ph < 8; ph++) begin
      no_idle = (ph == 3);
      set_all($urandom_range(0, 4194303) >> $urandom_range(0, 4),
              $urandom_range(0, 400000) >> $urandom_range(0, 8),
              $urandom_range(0, 65536), $urandom_range(1, 65535),
              $urandom_range(0, 2), $urandom_range(1, 3), (ph % 4 == 1));
      start_bins = bins_sent;
      start_updates = updates_seen;
      while (bins_sent - start_bins < 80 ||
             updates_seen + pending_updates.size() - start_updates < 4) begin
        if ($urandom_range(9) == 0)
          send_bin(2'($urandom), 6'($urandom_range(0, LAST_BIN - 1)), pick_count(),
                   pick_exposure());
        else
          send_frame(2'($urandom), $urandom_range(0, 5));
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    m_target = afe_pkg::TARGET_RST; m_band = afe_pkg::BAND_RST;
    m_decay = afe_pkg::DECAY_RST; m_maxexp = afe_pkg::MAXEXP_RST;
    m_skip = afe_pkg::SKIP_RST; m_accum = afe_pkg::ACCUM_RST; m_group = 0;
    for (int c = 0; c < NCAM; c++) begin
      m_wsum[c] = 0; m_ptot[c] = 0; m_fcnt[c] = 0; m_pmean[c] = 0;
      m_pvalid[c] = 1'b0; m_pgain[c] = afe_pkg::GAIN_ONE;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_regs();
    test_extremes();
    test_zero_pixels();
    test_group_mode();
    test_saturation();
    test_accum_below_skip();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d bin beats and checked %0d exposure updates over default, extreme,",
             bins_sent, updates_seen);
    $display("saturating, grouped, back-pressured and random register settings.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
